@@ design/acre_pkg.sv @@
// ----------------------------------------------------------------------------
// acre_pkg
// shared types, codes and constants of the alignment cigar run encoder
// ----------------------------------------------------------------------------
package acre_pkg;

    // widths of the fixed item fields
    localparam int CHAR_W          = 8;
    localparam int FIELD_W         = 24;
    localparam int COUNT_WIDTH_DEF = 24;

    // configuration port
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAP     = 2'd0,
        CFG_IGNORE  = 2'd1,
        CFG_UNKNOWN = 2'd2
    } t_cfg_idx;

    localparam logic [CHAR_W-1:0] GAP_CHAR_RST     = 8'd45;  // '-'
    localparam logic [CHAR_W-1:0] IGNORE_CHAR_RST  = 8'd46;  // '.'
    localparam logic [CHAR_W-1:0] UNKNOWN_CHAR_RST = 8'd78;  // 'N'

    // run operations
    localparam int OP_W = 3;

    typedef enum logic [OP_W-1:0] {
        OP_M = 3'd0,
        OP_I = 3'd1,
        OP_D = 3'd2,
        OP_X = 3'd3,
        OP_N = 3'd4
    } t_op;

    // column classes, one total each
    localparam int CLS_W       = 3;
    localparam int CLASS_COUNT = 6;

    typedef enum logic [CLS_W-1:0] {
        CLS_MATCH   = 3'd0,
        CLS_INSERT  = 3'd1,
        CLS_DELETE  = 3'd2,
        CLS_SUBST   = 3'd3,
        CLS_UNKNOWN = 3'd4,
        CLS_IGNORE  = 3'd5
    } t_class;

    // record kinds
    localparam logic REC_RUN     = 1'b0;
    localparam logic REC_SUMMARY = 1'b1;

    // command queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;

    // back end sequencing of one command
    typedef enum logic [1:0] {
        PH_COLUMN  = 2'd0,
        PH_FLUSH   = 2'd1,
        PH_SUMMARY = 2'd2
    } t_phase;

    typedef struct packed {
        logic [CHAR_W-1:0] ref_char;
        logic [CHAR_W-1:0] read_char;
        logic              final_column;
    } t_in_item;

    typedef struct packed {
        logic               record_kind;
        logic [OP_W-1:0]    op_code;
        logic [FIELD_W-1:0] run_length;
        logic [FIELD_W-1:0] longest_match;
        logic [FIELD_W-1:0] match_total;
        logic [FIELD_W-1:0] insert_total;
        logic [FIELD_W-1:0] delete_total;
        logic [FIELD_W-1:0] subst_total;
        logic [FIELD_W-1:0] unknown_total;
        logic [FIELD_W-1:0] ignore_total;
        logic               end_of_records;
    } t_out_item;

    // classified column
    typedef struct packed {
        logic   kept;
        t_op    op;
        t_class cls;
        logic   last;
    } t_cmd;

    typedef struct packed {
        logic push;
        t_cmd cmd;
    } t_q_wr;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_rd;

endpackage

@@ design/alignment_cigar_run_encoder_core.sv @@
// ----------------------------------------------------------------------------
// alignment_cigar_run_encoder_core
// cigar run-length encoder for a stream of aligned columns
// ----------------------------------------------------------------------------
//
// channel   direction  handshake            payload
// -------   ---------  -------------------  -------------------------------
// cfg       in         valid / ready        register index, 8-bit data
// in        in         valid / stall        t_in_item, one aligned column
// out       out        valid / stall        t_out_item, run or summary record
//
// - one column a cycle is accepted while the command queue has room
// - a column that ends no run passes only the column phase of the run encoder;
//   the final column also passes the flush phase, and the summary phase when a
//   run was still open; each phase emits at most one record
// - synchronous active-low reset clears run state, totals, queue and output valid
// - the input stalls only when the four-entry queue is full; the output
//   stage stalls on its own and the queue absorbs the difference
//
module alignment_cigar_run_encoder_core
    import acre_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration writes, always taken
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CHAR_W-1:0]    i_cfg_data,
    // aligned columns
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in,
    // run and summary records
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out
);

    t_q_wr q_wr;
    t_q_rd q_rd;
    logic  q_full;
    logic  q_pop;

    // registers are plain flops, a write never waits
    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = q_full;

    // front: config registers and column classification
    acre_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_in        (i_in),
        .i_q_full    (q_full),
        .o_q_wr      (q_wr)
    );

    // classified columns wait here while records drain
    acre_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_q_wr  (q_wr),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_q_rd  (q_rd)
    );

    // back: run tracking, totals, record output register
    acre_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_rd      (q_rd),
        .o_pop       (q_pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule

@@ design/acre_front.sv @@
// ----------------------------------------------------------------------------
// acre_front
// configuration registers and column classifier
// ----------------------------------------------------------------------------
module acre_front
    import acre_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CHAR_W-1:0]    i_cfg_data,
    input  logic                 i_in_valid,
    input  t_in_item             i_in,
    input  logic                 i_q_full,
    output t_q_wr                o_q_wr
);

    logic [CHAR_W-1:0] r_gap_char;
    logic [CHAR_W-1:0] r_ignore_char;
    logic [CHAR_W-1:0] r_unknown_char;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_char     <= GAP_CHAR_RST;
            r_ignore_char  <= IGNORE_CHAR_RST;
            r_unknown_char <= UNKNOWN_CHAR_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_GAP:     r_gap_char     <= i_cfg_data;
                CFG_IGNORE:  r_ignore_char  <= i_cfg_data;
                CFG_UNKNOWN: r_unknown_char <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic rd_ign, rd_gap, rc_gap;
    t_cmd cmd;

    always_comb begin
        rd_ign   = (i_in.read_char == r_ignore_char);
        rd_gap   = (i_in.read_char == r_gap_char);
        rc_gap   = (i_in.ref_char == r_gap_char);
        cmd      = '0;
        cmd.last = i_in.final_column;
        // gap against gap or ignore is dropped
        cmd.kept = !(rc_gap && (rd_ign || rd_gap));
        if (rd_ign) begin
            cmd.op  = OP_N;
            cmd.cls = CLS_IGNORE;
        end else if (i_in.ref_char == i_in.read_char) begin
            cmd.op  = OP_M;
            cmd.cls = CLS_MATCH;
        end else if (rd_gap) begin
            cmd.op  = OP_D;
            cmd.cls = CLS_DELETE;
        end else if (rc_gap) begin
            cmd.op  = OP_I;
            cmd.cls = CLS_INSERT;
        end else begin
            cmd.op  = OP_X;
            cmd.cls = (i_in.read_char == r_unknown_char) ? CLS_UNKNOWN : CLS_SUBST;
        end
    end

    assign o_q_wr.push = i_in_valid && !i_q_full;
    assign o_q_wr.cmd  = cmd;

endmodule

@@ design/acre_queue.sv @@
// ----------------------------------------------------------------------------
// acre_queue
// short command queue between classifier and run encoder
// ----------------------------------------------------------------------------
module acre_queue
    import acre_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_q_wr i_q_wr,
    input  logic  i_pop,
    output logic  o_full,
    output t_q_rd o_q_rd
);

    localparam logic [Q_PTR_W:0] FULL_CNT = (Q_PTR_W + 1)'(Q_DEPTH);

    t_cmd               r_data [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_PTR_W:0]   r_count;
    logic               do_pop;

    assign o_full        = (r_count == FULL_CNT);
    assign o_q_rd.valid  = (r_count != '0);
    assign o_q_rd.cmd    = r_data[r_rd_ptr];
    assign do_pop        = i_pop && o_q_rd.valid;

    always_ff @(posedge i_clk) begin
        if (i_q_wr.push) begin
            r_data[r_wr_ptr] <= i_q_wr.cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_q_wr.push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_q_wr.push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ design/acre_back.sv @@
// ----------------------------------------------------------------------------
// acre_back
// run-length encoder, class totals and output register
// ----------------------------------------------------------------------------
module acre_back
    import acre_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_q_rd     i_q_rd,
    output logic      o_pop,
    input  logic      i_out_stall,
    output logic      o_out_valid,
    output t_out_item o_out
);

    typedef logic [COUNT_WIDTH-1:0] t_cnt;

    function automatic t_cnt sat_inc(input t_cnt v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // low field bits of a counter, zero extended when the counter is narrow
    function automatic logic [FIELD_W-1:0] to_field(input t_cnt v);
        logic [COUNT_WIDTH+FIELD_W-1:0] w;
        w = {{FIELD_W{1'b0}}, v};
        return w[FIELD_W-1:0];
    endfunction

    t_phase    r_phase, n_phase;
    logic      r_run_open, n_run_open;
    t_op       r_open_op, n_open_op;
    t_cnt      r_run_count, n_run_count;
    t_cnt      r_best, n_best;
    t_cnt      r_totals [CLASS_COUNT];
    t_cnt      n_totals [CLASS_COUNT];
    logic      r_out_valid;
    t_out_item r_out;

    t_out_item rec;
    logic      emit, done, need_cmd, slot_free, go;
    t_cmd      cmd;

    assign cmd       = i_q_rd.cmd;
    assign slot_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_phase     = r_phase;
        n_run_open  = r_run_open;
        n_open_op   = r_open_op;
        n_run_count = r_run_count;
        n_best      = r_best;
        n_totals    = r_totals;
        rec         = '0;
        emit        = 1'b0;
        done        = 1'b0;
        need_cmd    = 1'b0;
        case (r_phase)
            PH_COLUMN: begin
                need_cmd = 1'b1;
                if (cmd.kept) begin
                    for (int j = 0; j < CLASS_COUNT; j++) begin
                        if (CLS_W'(j) == cmd.cls) begin
                            n_totals[j] = sat_inc(r_totals[j]);
                        end
                    end
                    if (!r_run_open) begin
                        n_run_open  = 1'b1;
                        n_open_op   = cmd.op;
                        n_run_count = t_cnt'(1);
                    end else if (cmd.op != r_open_op) begin
                        emit           = 1'b1;
                        rec.op_code    = r_open_op;
                        rec.run_length = to_field(r_run_count);
                        if (r_open_op == OP_M && r_run_count > r_best) begin
                            n_best = r_run_count;
                        end
                        n_open_op   = cmd.op;
                        n_run_count = t_cnt'(1);
                    end else begin
                        n_run_count = sat_inc(r_run_count);
                    end
                end
                if (cmd.last) begin
                    n_phase = PH_FLUSH;
                end else begin
                    done = 1'b1;
                end
            end
            PH_FLUSH: begin
                if (r_run_open) begin
                    emit           = 1'b1;
                    rec.op_code    = r_open_op;
                    rec.run_length = to_field(r_run_count);
                    if (r_open_op == OP_M && r_run_count > r_best) begin
                        n_best = r_run_count;
                    end
                    n_run_open = 1'b0;
                    n_phase    = PH_SUMMARY;
                end else begin
                    n_phase = PH_SUMMARY;
                end
            end
            default: begin
                n_phase = PH_COLUMN;
            end
        endcase

        // summary: straight from the flush phase when no run is open
        if (r_phase == PH_SUMMARY || (r_phase == PH_FLUSH && !r_run_open)) begin
            emit               = 1'b1;
            done               = 1'b1;
            rec.record_kind    = REC_SUMMARY;
            rec.end_of_records = 1'b1;
            rec.longest_match  = to_field(r_best);
            rec.match_total    = to_field(r_totals[CLS_MATCH]);
            rec.insert_total   = to_field(r_totals[CLS_INSERT]);
            rec.delete_total   = to_field(r_totals[CLS_DELETE]);
            rec.subst_total    = to_field(r_totals[CLS_SUBST]);
            rec.unknown_total  = to_field(r_totals[CLS_UNKNOWN]);
            rec.ignore_total   = to_field(r_totals[CLS_IGNORE]);
            n_phase            = PH_COLUMN;
            n_run_open         = 1'b0;
            n_open_op          = OP_M;
            n_run_count        = '0;
            n_best             = '0;
            for (int j = 0; j < CLASS_COUNT; j++) begin
                n_totals[j] = '0;
            end
        end
    end

    assign go    = (!need_cmd || i_q_rd.valid) && (!emit || slot_free);
    assign o_pop = go && done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_COLUMN;
            r_run_open  <= 1'b0;
            r_open_op   <= OP_M;
            r_run_count <= '0;
            r_best      <= '0;
            for (int j = 0; j < CLASS_COUNT; j++) begin
                r_totals[j] <= '0;
            end
        end else if (go) begin
            r_phase     <= n_phase;
            r_run_open  <= n_run_open;
            r_open_op   <= n_open_op;
            r_run_count <= n_run_count;
            r_best      <= n_best;
            r_totals    <= n_totals;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (go && emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go && emit) begin
            r_out <= rec;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

@@ design/acre_checker.sv @@
// ----------------------------------------------------------------------------
// acre_checker
// port-level checks on the run encoder, bound to the top level
// ----------------------------------------------------------------------------
module acre_checker
    import acre_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_in_stall,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input t_out_item            o_out
);

    logic out_xfer;
    logic run_xfer;

    assign out_xfer = o_out_valid && !i_out_stall;
    assign run_xfer = out_xfer && (o_out.record_kind == REC_RUN);

    // a stalled record stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("record dropped while stalled");

    // a stalled record keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out))
        else $error("record changed while stalled");

    // back-to-back run records always change operation
    a_run_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        run_xfer && $past(run_xfer) |-> o_out.op_code != $past(o_out.op_code))
        else $error("two adjacent runs share an operation");

    // reset leaves an empty pipe: nothing offered, room for a column
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("pipe not empty after reset");

endmodule

bind alignment_cigar_run_encoder_core acre_checker u_acre_checker (.*);
